// ===== rtl/whmf_pkg.sv =====
// ---------------------------------------------------------------------------
// whmf_pkg
// Shared types, field layout and helpers of the weighted histogram fill unit.
// ---------------------------------------------------------------------------
`default_nettype none

package whmf_pkg;

    // Field widths
    localparam int COORD_BITS    = 16;
    localparam int MAX_DIMS      = 2;
    localparam int BIN_DEPTH_DEF = 4096;
    localparam int WEIGHT_W      = 16;
    localparam int BIN_W         = 12;
    localparam int CONTENT_W     = 32;
    localparam int EVENT_W       = 32;
    localparam int WSUM_W        = 40;
    localparam int BINS_W        = 7;
    localparam int LBIN_W        = 6;
    localparam int AXIS_BIN_CAP  = 64;
    localparam int BIN_SPAN      = 1 << BIN_W;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Shared divider: numerator holds (value - lower) * bins
    localparam int DIV_Q_W   = 8;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W - 1;

    localparam int QUEUE_DEPTH = 2;

    // Input word layout
    localparam int IN_X_LSB   = 0;
    localparam int IN_Y_LSB   = IN_X_LSB + COORD_BITS;
    localparam int IN_W_LSB   = IN_Y_LSB + COORD_BITS;
    localparam int IN_IDX_LSB = IN_W_LSB + WEIGHT_W;
    localparam int IN_USED_W  = IN_IDX_LSB + BIN_W;
    localparam int S_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Output word layout
    localparam int OUT_BIN_LSB  = 0;
    localparam int OUT_CONT_LSB = OUT_BIN_LSB + BIN_W;
    localparam int OUT_EVT_LSB  = OUT_CONT_LSB + CONTENT_W;
    localparam int OUT_WSUM_LSB = OUT_EVT_LSB + EVENT_W;
    localparam int OUT_USED_W   = OUT_WSUM_LSB + WSUM_W;
    localparam int M_TDATA_W    = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = M_TDATA_W - OUT_USED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS_USED = 3'd0,
        CFG_LOWER_X   = 3'd1,
        CFG_UPPER_X   = 3'd2,
        CFG_BINS_X    = 3'd3,
        CFG_LOWER_Y   = 3'd4,
        CFG_UPPER_Y   = 3'd5,
        CFG_BINS_Y    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]            dims_used;
        logic [COORD_BITS-1:0] lower_x;
        logic [COORD_BITS-1:0] upper_x;
        logic [BINS_W-1:0]     bins_x;
        logic [COORD_BITS-1:0] lower_y;
        logic [COORD_BITS-1:0] upper_y;
        logic [BINS_W-1:0]     bins_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dims_used: 2'd1,
        lower_x:   16'sd0,
        upper_x:   16'sd32767,
        bins_x:    7'd64,
        lower_y:   16'sd0,
        upper_y:   16'sd32767,
        bins_y:    7'd1
    };

    // One word handed from the front to the back
    typedef struct packed {
        logic                is_read;
        logic [BIN_W-1:0]    bin_number;
        logic                in_range;
        logic [WEIGHT_W-1:0] weight;
        logic                clamped;
    } queue_entry_t;

    // Bin count 0 acts as 1, anything above the cap acts as the cap
    function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] b);
        logic [BINS_W-1:0] r;
        priority if (b == '0) begin
            r = BINS_W'(1);
        end else if (b > BINS_W'(AXIS_BIN_CAP)) begin
            r = BINS_W'(AXIS_BIN_CAP);
        end else begin
            r = b;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/whmf_ram.sv =====
// ---------------------------------------------------------------------------
// whmf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                             aclk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/whmf_div.sv =====
// ---------------------------------------------------------------------------
// whmf_div
// Restoring divider, one quotient bit per cycle; quotient must fit DIV_Q_W.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_div (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [whmf_pkg::DIV_NUM_W-1:0]   num,
    input  wire logic [whmf_pkg::DIV_DEN_W-1:0]   den,
    output logic                                  done,
    output logic      [whmf_pkg::DIV_Q_W-1:0]     quot,
    output logic      [whmf_pkg::DIV_NUM_W-1:0]   rem
);

    localparam int NW = whmf_pkg::DIV_NUM_W;
    localparam int QW = whmf_pkg::DIV_Q_W;
    localparam int CW = $clog2(QW);

    logic [NW-1:0] rem_reg;
    logic [NW-1:0] dsh_reg;
    logic [QW-1:0] quot_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          ge;

    assign ge = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            dsh_reg  <= NW'(den) << (QW - 1);
            quot_reg <= '0;
            cnt_reg  <= CW'(QW - 1);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quot_reg <= {quot_reg[QW-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/whmf_fifo.sv =====
// ---------------------------------------------------------------------------
// whmf_fifo
// Short register queue between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  din,
    output logic                   full,
    input  wire logic              pop,
    output logic      [WIDTH-1:0]  dout,
    output logic                   empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg;
    logic [PW-1:0]    rptr_reg;
    logic [CW-1:0]    cnt_reg;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign dout  = mem_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/whmf_front.sv =====
// ---------------------------------------------------------------------------
// whmf_front
// Accepts words, holds the configuration and works out the global bin of a
// fill through clamping and a shared iterative divider.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_front #(
    parameter int BIN_DEPTH = whmf_pkg::BIN_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [whmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [whmf_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [whmf_pkg::S_TDATA_W-1:0]      s_tdata,
    input  wire logic                                s_tuser,
    input  wire logic                                clearing,
    output logic                                     q_push,
    output whmf_pkg::queue_entry_t                   q_entry,
    input  wire logic                                q_full
);

    localparam int  CB       = whmf_pkg::COORD_BITS;
    localparam int  BW       = whmf_pkg::BIN_W;
    localparam int  NBW      = whmf_pkg::BINS_W;
    localparam int  LBW      = whmf_pkg::LBIN_W;
    localparam int  NW       = whmf_pkg::DIV_NUM_W;
    localparam int  DW       = whmf_pkg::DIV_DEN_W;
    localparam int  QW       = whmf_pkg::DIV_Q_W;
    localparam bit  NEED_MOD = BIN_DEPTH < whmf_pkg::BIN_SPAN;

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_AX   = 7'b0000010,
        F_MUL  = 7'b0000100,
        F_DIV  = 7'b0001000,
        F_COMB = 7'b0010000,
        F_MODW = 7'b0100000,
        F_PUSH = 7'b1000000
    } front_state_t;

    front_state_t              state_reg, state_next;
    whmf_pkg::cfg_t            cfg_reg, cfg_next;
    whmf_pkg::queue_entry_t    entry_reg;

    logic [CB-1:0]                 cx_reg, cy_reg, vc_reg;
    logic [whmf_pkg::WEIGHT_W-1:0] w_reg;
    logic                          axis_y_reg, empty_reg, clamped_reg;
    logic [LBW-1:0]                lx_reg, ly_reg;

    logic            accept, two_dims, axis_last, axis_done;
    logic [NBW-1:0]  nb_x, nb_y, ax_nb;
    logic [CB-1:0]   ax_v, ax_lo, ax_hi, v_lo, v_c, diff, den;
    logic            below, above, ax_empty;
    logic [NW-1:0]   mul_num;
    logic [QW-1:0]   div_quot;
    logic [NW-1:0]   div_rem;
    logic            div_done, div_start;
    logic [NW-1:0]   div_num;
    logic [DW-1:0]   div_den;
    logic [LBW-1:0]  q_sat, bin_val;
    logic [BW-1:0]   glob;
    logic [BW-1:0]   s_idx;

    assign s_idx    = s_tdata[whmf_pkg::IN_IDX_LSB +: BW];
    assign s_tready = (state_reg == F_IDLE) && !clearing;
    assign accept   = s_tvalid && s_tready;

    // Two dimensions when dims_used is 2 or 3
    assign two_dims  = (whmf_pkg::MAX_DIMS == 2) && cfg_reg.dims_used[1];
    assign axis_last = axis_y_reg || !two_dims;
    assign nb_x      = whmf_pkg::eff_bins(cfg_reg.bins_x);
    assign nb_y      = whmf_pkg::eff_bins(cfg_reg.bins_y);

    assign ax_v  = axis_y_reg ? cy_reg : cx_reg;
    assign ax_lo = axis_y_reg ? cfg_reg.lower_y : cfg_reg.lower_x;
    assign ax_hi = axis_y_reg ? cfg_reg.upper_y : cfg_reg.upper_x;
    assign ax_nb = axis_y_reg ? nb_y : nb_x;

    // Clamp to lower first, then to upper
    assign below    = $signed(ax_v) < $signed(ax_lo);
    assign v_lo     = below ? ax_lo : ax_v;
    assign above    = $signed(v_lo) > $signed(ax_hi);
    assign v_c      = above ? ax_hi : v_lo;
    assign ax_empty = $signed(ax_hi) <= $signed(ax_lo);

    // Both differences are non-negative and fit CB bits once the range is valid
    assign diff    = vc_reg - ax_lo;
    assign den     = ax_hi - ax_lo;
    assign mul_num = NW'(diff) * NW'(ax_nb);

    // Value at upper lands one past the last bin
    assign q_sat   = (div_quot >= QW'(ax_nb)) ? LBW'(ax_nb - 1'b1) : LBW'(div_quot);
    assign bin_val = empty_reg ? '0 : q_sat;

    assign axis_done = ((state_reg == F_MUL) && empty_reg) ||
                       ((state_reg == F_DIV) && div_done);

    assign glob = BW'(lx_reg) + BW'(ly_reg) * BW'(nb_x);

    assign div_start = ((state_reg == F_MUL) && !empty_reg) ||
                       ((state_reg == F_COMB) && NEED_MOD);
    assign div_num   = (state_reg == F_COMB) ? NW'(glob) : mul_num;
    assign div_den   = (state_reg == F_COMB) ? DW'(BIN_DEPTH) : den;

    whmf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_comb begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            whmf_pkg::CFG_DIMS_USED: cfg_next.dims_used = cfg_wdata[1:0];
            whmf_pkg::CFG_LOWER_X:   cfg_next.lower_x   = cfg_wdata[CB-1:0];
            whmf_pkg::CFG_UPPER_X:   cfg_next.upper_x   = cfg_wdata[CB-1:0];
            whmf_pkg::CFG_BINS_X:    cfg_next.bins_x    = cfg_wdata[NBW-1:0];
            whmf_pkg::CFG_LOWER_Y:   cfg_next.lower_y   = cfg_wdata[CB-1:0];
            whmf_pkg::CFG_UPPER_Y:   cfg_next.upper_y   = cfg_wdata[CB-1:0];
            whmf_pkg::CFG_BINS_Y:    cfg_next.bins_y    = cfg_wdata[NBW-1:0];
            default:                 cfg_next = cfg_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = s_tuser ? F_PUSH : F_AX;
                end
            end
            F_AX:   state_next = F_MUL;
            F_MUL: begin
                if (empty_reg) begin
                    state_next = axis_last ? F_COMB : F_AX;
                end else begin
                    state_next = F_DIV;
                end
            end
            F_DIV: begin
                if (div_done) begin
                    state_next = axis_last ? F_COMB : F_AX;
                end
            end
            F_COMB: state_next = NEED_MOD ? F_MODW : F_PUSH;
            F_MODW: begin
                if (div_done) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!q_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cfg_reg   <= whmf_pkg::CFG_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                cfg_reg <= cfg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg              <= s_tdata[whmf_pkg::IN_X_LSB +: CB];
            cy_reg              <= s_tdata[whmf_pkg::IN_Y_LSB +: CB];
            w_reg               <= s_tdata[whmf_pkg::IN_W_LSB +: whmf_pkg::WEIGHT_W];
            axis_y_reg          <= 1'b0;
            clamped_reg         <= 1'b0;
            ly_reg              <= '0;
            entry_reg.is_read    <= 1'b1;
            entry_reg.bin_number <= s_idx;
            entry_reg.in_range   <= 32'(s_idx) < BIN_DEPTH;
            entry_reg.weight     <= '0;
            entry_reg.clamped    <= 1'b0;
        end
        if (state_reg == F_AX) begin
            vc_reg      <= v_c;
            empty_reg   <= ax_empty;
            clamped_reg <= clamped_reg | below | above;
        end
        if (axis_done) begin
            if (axis_y_reg) begin
                ly_reg <= bin_val;
            end else begin
                lx_reg <= bin_val;
            end
            if (!axis_last) begin
                axis_y_reg <= 1'b1;
            end
        end
        if (state_reg == F_COMB) begin
            entry_reg.is_read    <= 1'b0;
            entry_reg.bin_number <= glob;
            entry_reg.in_range   <= 1'b1;
            entry_reg.weight     <= w_reg;
            entry_reg.clamped    <= clamped_reg;
        end
        if ((state_reg == F_MODW) && div_done) begin
            entry_reg.bin_number <= BW'(div_rem);
        end
    end

    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign q_entry = entry_reg;

endmodule

`default_nettype wire

// ===== rtl/whmf_back.sv =====
// ---------------------------------------------------------------------------
// whmf_back
// Clears the bin store after reset, then runs read-modify-write of bins,
// the event and weight totals, and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_back #(
    parameter int BIN_DEPTH = whmf_pkg::BIN_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_empty,
    output logic                                   q_pop,
    input  wire whmf_pkg::queue_entry_t            q_entry,
    output logic                                   clearing,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [whmf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                                   m_tuser
);

    localparam int AW = $clog2(BIN_DEPTH);
    localparam int CTW = whmf_pkg::CONTENT_W;
    localparam int EW  = whmf_pkg::EVENT_W;
    localparam int SW  = whmf_pkg::WSUM_W;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_UPD   = 3'b100
    } back_state_t;

    back_state_t              state_reg, state_next;
    logic [AW-1:0]            clr_addr_reg;
    whmf_pkg::queue_entry_t   ent_reg;
    logic [EW-1:0]            evt_reg, evt_next;
    logic [SW-1:0]            wsum_reg, wsum_next;

    logic                     m_valid_reg;
    logic [whmf_pkg::BIN_W-1:0] m_bin_reg;
    logic [CTW-1:0]           m_content_reg;
    logic [EW-1:0]            m_evt_reg;
    logic [SW-1:0]            m_wsum_reg;
    logic                     m_clamp_reg;

    logic                     ram_we, ram_re, upd_fire, clr_last;
    logic [AW-1:0]            ram_waddr;
    logic [CTW-1:0]           ram_wdata, ram_rdata;
    logic [CTW:0]             bin_sum;
    logic [CTW-1:0]           bin_sat, content;
    logic [SW:0]              wsum_add;

    assign clearing = state_reg == B_CLEAR;
    assign clr_last = clr_addr_reg == AW'(BIN_DEPTH - 1);

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign ram_re   = q_pop;
    assign upd_fire = (state_reg == B_UPD) && (!m_valid_reg || m_tready);

    assign bin_sum  = {1'b0, ram_rdata} + (CTW + 1)'(ent_reg.weight);
    assign bin_sat  = bin_sum[CTW] ? '1 : bin_sum[CTW-1:0];
    assign wsum_add = {1'b0, wsum_reg} + (SW + 1)'(ent_reg.weight);

    always_comb begin
        evt_next  = evt_reg;
        wsum_next = wsum_reg;
        content   = ent_reg.in_range ? ram_rdata : '0;
        if (!ent_reg.is_read) begin
            evt_next  = (evt_reg == '1) ? evt_reg : evt_reg + 1'b1;
            wsum_next = wsum_add[SW] ? '1 : wsum_add[SW-1:0];
            content   = bin_sat;
        end
    end

    assign ram_we    = clearing || (upd_fire && !ent_reg.is_read);
    assign ram_waddr = clearing ? clr_addr_reg : AW'(ent_reg.bin_number);
    assign ram_wdata = clearing ? '0 : bin_sat;

    whmf_ram #(
        .WIDTH (CTW),
        .DEPTH (BIN_DEPTH)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (AW'(q_entry.bin_number)),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR: begin
                if (clr_last) begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE: begin
                if (q_pop) begin
                    state_next = B_UPD;
                end
            end
            B_UPD: begin
                if (upd_fire) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            evt_reg      <= '0;
            wsum_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (upd_fire) begin
                evt_reg     <= evt_next;
                wsum_reg    <= wsum_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_entry;
        end
        if (upd_fire) begin
            m_bin_reg     <= ent_reg.bin_number;
            m_content_reg <= content;
            m_evt_reg     <= evt_next;
            m_wsum_reg    <= wsum_next;
            m_clamp_reg   <= ent_reg.clamped;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{whmf_pkg::OUT_PAD_W{1'b0}}, m_wsum_reg, m_evt_reg,
                       m_content_reg, m_bin_reg};
    assign m_tuser  = m_clamp_reg;

endmodule

`default_nettype wire

// ===== rtl/weighted_multidim_histogram_fill_unit.sv =====
// ---------------------------------------------------------------------------
// weighted_multidim_histogram_fill_unit
// Weighted 1-D / 2-D histogram with saturating bins and running totals.
// ---------------------------------------------------------------------------
// Every input word gives exactly one output word, in order. After reset the
// unit clears all BIN_DEPTH bins, one per cycle, and holds s_tready low until
// all are clear. A read word goes straight from acceptance to the hand-over
// in the front. A fill, per active axis, clamps the value and runs the 8-step
// shared divider that scales (value - lower) * bins by the range width, then
// combines the axis bins and hands over; with BIN_DEPTH below 4096 the wrap
// of the global bin runs through the same divider. The front takes a new
// word only once it has handed the last one to the queue. The back (bin
// read-modify-write) overlaps the next word's front work through a
// two-entry queue, and the output register lets the front keep accepting
// while a result waits, until the queue is full.
`default_nettype none

module weighted_multidim_histogram_fill_unit #(
    parameter int BIN_DEPTH = whmf_pkg::BIN_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [whmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [whmf_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // coord_x, coord_y, event_weight, read_index, zero pad
    input  wire logic [whmf_pkg::S_TDATA_W-1:0]    s_tdata,
    // func
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // bin_number, bin_content, events_added, weight_total, zero pad
    output logic      [whmf_pkg::M_TDATA_W-1:0]    m_tdata,
    // was_clamped
    output logic                                   m_tuser
);

    localparam int EW = $bits(whmf_pkg::queue_entry_t);

    whmf_pkg::queue_entry_t push_entry, pop_entry;
    logic                   q_push, q_pop, q_full, q_empty, clearing;

    whmf_front #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_entry   (push_entry),
        .q_full    (q_full)
    );

    whmf_fifo #(
        .WIDTH (EW),
        .DEPTH (whmf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_entry),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (pop_entry),
        .empty   (q_empty)
    );

    whmf_back #(
        .BIN_DEPTH (BIN_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_entry  (pop_entry),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/whmf_checker.sv =====
// ---------------------------------------------------------------------------
// whmf_checker
// Port-level checks of the histogram fill unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module whmf_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              cfg_wr_en,
    input wire logic [whmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input wire logic [whmf_pkg::CFG_W-1:0]        cfg_wdata,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [whmf_pkg::S_TDATA_W-1:0]    s_tdata,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [whmf_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic                              m_tuser
);

    localparam int EW = whmf_pkg::EVENT_W;
    localparam int SW = whmf_pkg::WSUM_W;

    logic          seen_reg;
    logic [EW-1:0] last_evt_reg;
    logic [SW-1:0] last_wsum_reg;
    logic [EW-1:0] evt;
    logic [SW-1:0] wsum;
    logic          m_fire;

    assign evt    = m_tdata[whmf_pkg::OUT_EVT_LSB +: EW];
    assign wsum   = m_tdata[whmf_pkg::OUT_WSUM_LSB +: SW];
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_fire) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_fire) begin
            last_evt_reg  <= evt;
            last_wsum_reg <= wsum;
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Totals only grow from word to word
    a_evt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && seen_reg |-> evt >= last_evt_reg)
        else $error("event count went down");

    a_wsum_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && seen_reg |-> wsum >= last_wsum_reg)
        else $error("weight total went down");

    // With no fill yet there is no weight and nothing clamped
    a_zero_evt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (evt == '0) |-> (wsum == '0) && !m_tuser)
        else $error("weight or clamp flag without any fill");

endmodule

bind weighted_multidim_histogram_fill_unit whmf_checker u_whmf_checker (.*);

`default_nettype wire
